### rtl/isds_pkg.sv
package isds_pkg;

    localparam int FIELD_W = 32;
    localparam int OP_W    = 4;
    localparam int ST_W    = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_BACK  = 4'd0,
        OP_PUSH_FRONT = 4'd1,
        OP_POP_BACK   = 4'd2,
        OP_POP_FRONT  = 4'd3,
        OP_READ_FRONT = 4'd4,
        OP_READ_BACK  = 4'd5,
        OP_READ_AT    = 4'd6,
        OP_WRITE_AT   = 4'd7,
        OP_INSERT_AT  = 4'd8,
        OP_ERASE_AT   = 4'd9,
        OP_CLEAR      = 4'd10
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CM_HOLD   = 2'd0,
        CM_WRITE  = 2'd1,
        CM_INSERT = 2'd2,
        CM_ERASE  = 2'd3
    } cell_mode_t;

endpackage

### rtl/isds_cell.sv
module isds_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int CNT_W      = 5,
    parameter int INDEX      = 0
) (
    input  logic                  clk,
    input  isds_pkg::cell_mode_t  mode,
    input  logic [CNT_W-1:0]      pos,
    input  logic [DATA_WIDTH-1:0] load_word,
    input  logic [DATA_WIDTH-1:0] left_word,
    input  logic [DATA_WIDTH-1:0] right_word,
    output logic [DATA_WIDTH-1:0] word
);
    import isds_pkg::*;

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(INDEX);

    logic [DATA_WIDTH-1:0] word_reg;
    logic [DATA_WIDTH-1:0] word_next;

    always_comb
    begin
        word_next = word_reg;
        case (mode)
            CM_WRITE:
            begin
                if (MY_IDX == pos)
                begin
                    word_next = load_word;
                end
            end
            CM_INSERT:
            begin
                if (MY_IDX == pos)
                begin
                    word_next = load_word;
                end
                else if (MY_IDX > pos)
                begin
                    word_next = left_word;
                end
            end
            CM_ERASE:
            begin
                if (MY_IDX >= pos)
                begin
                    word_next = right_word;
                end
            end
            default:
            begin
                word_next = word_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

### rtl/isds_out_buf.sv
module isds_out_buf #(
    parameter int WIDTH = 40
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [WIDTH-1:0] out_data
);
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [WIDTH-1:0] out_data_reg;
    logic [WIDTH-1:0] out_data_next;
    logic             skid_valid_reg;
    logic             skid_valid_next;
    logic [WIDTH-1:0] skid_data_reg;
    logic [WIDTH-1:0] skid_data_next;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                if (push)
                begin
                    out_data_next = push_data;
                end
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### rtl/indexed_sequence_store.sv
// Channel   Signals                                   Direction  Transfer when
// req       req_valid req_stall operation position     in         req_valid && !req_stall
//           value
// rsp       rsp_valid rsp_stall read_value count       out        rsp_valid && !rsp_stall
//           is_empty status
//
// One operation per cycle while req_stall is low; its result is registered in the output buffer.
// Every cell of the chain loads, shifts or holds in the same cycle.
// A two-entry output buffer lets one more request in while a result waits.
// Asynchronous reset empties the store; cell contents are not cleared.
// req_stall rises only when both output entries are occupied.
module indexed_sequence_store #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    req_valid,
    output logic                                    req_stall,
    input  logic [isds_pkg::OP_W-1:0]               operation,
    input  logic [$clog2(CAPACITY+1)-1:0]           position,
    input  logic [isds_pkg::FIELD_W-1:0]            value,
    output logic                                    rsp_valid,
    input  logic                                    rsp_stall,
    output logic [isds_pkg::FIELD_W-1:0]            read_value,
    output logic [$clog2(CAPACITY+1)-1:0]           count,
    output logic                                    is_empty,
    output logic [isds_pkg::ST_W-1:0]               status
);
    import isds_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int RSP_W = FIELD_W + CNT_W + 1 + ST_W;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  req_fire;
    logic                  full;
    logic                  empty;
    cell_mode_t            mode;
    cell_mode_t            cell_mode;
    logic [CNT_W-1:0]      cell_pos;
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_idx;
    status_t               st;
    logic [CNT_W-1:0]      last_pos;
    logic [DATA_WIDTH-1:0] load_word;
    logic [DATA_WIDTH-1:0] words [CAPACITY];
    logic [FIELD_W-1:0]    rd_word;
    logic [RSP_W-1:0]      rsp_push_data;
    logic [RSP_W-1:0]      rsp_data;
    logic                  buf_full;

    assign req_stall = buf_full;
    assign req_fire  = req_valid && !buf_full;
    assign full      = (count_reg == FULL_CNT);
    assign empty     = (count_reg == '0);
    assign last_pos  = count_reg - CNT_W'(1);
    assign load_word = DATA_WIDTH'(value);

    always_comb
    begin
        mode       = CM_HOLD;
        cell_pos   = position;
        count_next = count_reg;
        rd_en      = 1'b0;
        rd_idx     = '0;
        st         = ST_OK;
        case (op_t'(operation))
            OP_PUSH_BACK:
            begin
                if (full)
                begin
                    st = ST_FULL;
                end
                else
                begin
                    mode       = CM_INSERT;
                    cell_pos   = count_reg;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_PUSH_FRONT:
            begin
                if (full)
                begin
                    st = ST_FULL;
                end
                else
                begin
                    mode       = CM_INSERT;
                    cell_pos   = '0;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_POP_BACK:
            begin
                if (empty)
                begin
                    st = ST_EMPTY;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_idx     = last_pos[IDX_W-1:0];
                    count_next = last_pos;
                end
            end
            OP_POP_FRONT:
            begin
                if (empty)
                begin
                    st = ST_EMPTY;
                end
                else
                begin
                    rd_en      = 1'b1;
                    mode       = CM_ERASE;
                    cell_pos   = '0;
                    count_next = last_pos;
                end
            end
            OP_READ_FRONT:
            begin
                if (empty)
                begin
                    st = ST_EMPTY;
                end
                else
                begin
                    rd_en = 1'b1;
                end
            end
            OP_READ_BACK:
            begin
                if (empty)
                begin
                    st = ST_EMPTY;
                end
                else
                begin
                    rd_en  = 1'b1;
                    rd_idx = last_pos[IDX_W-1:0];
                end
            end
            OP_READ_AT:
            begin
                if (position >= count_reg)
                begin
                    st = ST_RANGE;
                end
                else
                begin
                    rd_en  = 1'b1;
                    rd_idx = position[IDX_W-1:0];
                end
            end
            OP_WRITE_AT:
            begin
                if (position >= count_reg)
                begin
                    st = ST_RANGE;
                end
                else
                begin
                    mode = CM_WRITE;
                end
            end
            OP_INSERT_AT:
            begin
                if (position > count_reg)
                begin
                    st = ST_RANGE;
                end
                else if (full)
                begin
                    st = ST_FULL;
                end
                else
                begin
                    mode       = CM_INSERT;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_ERASE_AT:
            begin
                if (position >= count_reg)
                begin
                    st = ST_RANGE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_idx     = position[IDX_W-1:0];
                    mode       = CM_ERASE;
                    count_next = last_pos;
                end
            end
            OP_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                st = ST_OK;
            end
        endcase
    end

    assign cell_mode = req_fire ? mode : CM_HOLD;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [DATA_WIDTH-1:0] left_word;
            logic [DATA_WIDTH-1:0] right_word;
            if (gi == 0)
            begin : g_first
                assign left_word = load_word;
            end
            else
            begin : g_mid_l
                assign left_word = words[gi-1];
            end
            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_word = words[gi];
            end
            else
            begin : g_mid_r
                assign right_word = words[gi+1];
            end
            isds_cell #(
                .DATA_WIDTH (DATA_WIDTH),
                .CNT_W      (CNT_W),
                .INDEX      (gi)
            ) u_cell (
                .clk        (clk),
                .mode       (cell_mode),
                .pos        (cell_pos),
                .load_word  (load_word),
                .left_word  (left_word),
                .right_word (right_word),
                .word       (words[gi])
            );
        end
    endgenerate

    assign rd_word       = rd_en ? FIELD_W'($signed(words[rd_idx])) : '0;
    assign rsp_push_data = {rd_word, count_next, (count_next == '0), st};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (req_fire)
        begin
            count_reg <= count_next;
        end
    end

    isds_out_buf #(
        .WIDTH (RSP_W)
    ) u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (req_fire),
        .push_data (rsp_push_data),
        .full      (buf_full),
        .out_valid (rsp_valid),
        .out_stall (rsp_stall),
        .out_data  (rsp_data)
    );

    assign read_value = rsp_data[RSP_W-1 -: FIELD_W];
    assign count      = rsp_data[ST_W+1 +: CNT_W];
    assign is_empty   = rsp_data[ST_W];
    assign status     = rsp_data[ST_W-1:0];

endmodule

### rtl/isds_checker.sv
module isds_checker #(
    parameter int CAPACITY = 16
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                req_valid,
    input logic                                req_stall,
    input logic                                rsp_valid,
    input logic                                rsp_stall,
    input logic [isds_pkg::FIELD_W-1:0]        read_value,
    input logic [$clog2(CAPACITY+1)-1:0]       count,
    input logic                                is_empty,
    input logic [isds_pkg::ST_W-1:0]           status
);
    import isds_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(read_value) && $stable(count)
            && $stable(status) && $stable(is_empty))
        else $error("result changed while stalled");

    a_stall_needs_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> rsp_valid)
        else $error("request stalled with no result pending");

    a_rsp_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_valid && !req_stall))
        else $error("result appeared with no request transfer");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (is_empty == (count == '0)))
        else $error("empty flag disagrees with count");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status != ST_OK) |-> (read_value == '0))
        else $error("refused operation returned data");

endmodule

bind indexed_sequence_store isds_checker #(
    .CAPACITY (CAPACITY)
) u_isds_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .read_value (read_value),
    .count      (count),
    .is_empty   (is_empty),
    .status     (status)
);
